@@ rtl/core/uart_bq_pkg.sv @@
// ----------------------------------------------------------------------------
// uart_bq_pkg
// Shared types and constants for the buffered UART transmit/receive queues.
// ----------------------------------------------------------------------------
package uart_bq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_READ   = 2'd1,
      REQ_RX     = 2'd2,
      REQ_TXDONE = 2'd3
   } req_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;       // beat accepted, act on it now
      logic load_pop;   // registered queue read is ready, build the result
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop_needed; // offered beat pops a non-empty queue
   } dp_stat_type;

endpackage

@@ rtl/core/uart_buffered_tx_rx_queues.sv @@
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queues
// Transmit and receive byte ring queues between software and a UART line.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one response beat. Writes, line receives,
// transmit-complete with an empty queue and reads of an empty queue load the
// response register directly; a read or transmit-complete that pops a queue
// goes through the registered read of the queue memory first. Each queue holds
// at most QUEUE_DEPTH-1 bytes. A new request is taken once any queue read has
// finished and the response register is free or being emptied in the same
// cycle, so the request side is not ready while a queue read is under way.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues
   import uart_bq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] line_byte, [8] write_accepted, [16:9] read_byte, [17] rx_dropped,
   // [18] busy_flag, [23:19] zero
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // [0] line_load, [1] read_valid
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   logic       line_load, write_accepted, read_valid, rx_dropped, busy_flag;
   logic [7:0] line_byte, read_byte;

   uart_bq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   uart_bq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_tuser),
      .data_byte      (req_tdata),
      .cmd            (cmd),
      .stat           (stat),
      .line_load      (line_load),
      .line_byte      (line_byte),
      .write_accepted (write_accepted),
      .read_valid     (read_valid),
      .read_byte      (read_byte),
      .rx_dropped     (rx_dropped),
      .busy_flag      (busy_flag)
   );

   assign rsp_tdata = {5'd0, busy_flag, rx_dropped, read_byte, write_accepted, line_byte};
   assign rsp_tuser = {read_valid, line_load};

endmodule

@@ rtl/core/uart_bq_ctrl.sv @@
// ----------------------------------------------------------------------------
// uart_bq_ctrl
// Sequencer: takes request beats, waits out the queue read, owns the
// result valid flag.
// ----------------------------------------------------------------------------
module uart_bq_ctrl
   import uart_bq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.exec     = accept;
   assign cmd.load_pop = (state_ff == ST_POP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.pop_needed) state_in = ST_POP;
         end
         ST_POP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == ST_POP) rsp_valid_in = 1'b1;
      else if (accept && !stat.pop_needed) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/uart_bq_datapath.sv @@
// ----------------------------------------------------------------------------
// uart_bq_datapath
// Transmit and receive ring queues, transmitter busy flag and result register.
// ----------------------------------------------------------------------------
module uart_bq_datapath
   import uart_bq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   req_type,
   input  logic [7:0]   data_byte,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic         line_load,
   output logic [7:0]   line_byte,
   output logic         write_accepted,
   output logic         read_valid,
   output logic [7:0]   read_byte,
   output logic         rx_dropped,
   output logic         busy_flag
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [7:0] tx_mem [QUEUE_DEPTH];
   logic [7:0] rx_mem [QUEUE_DEPTH];
   logic [7:0] tx_rd_ff, rx_rd_ff;

   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0] tx_head_nxt, tx_tail_nxt, rx_head_nxt, rx_tail_nxt;
   logic             tx_active_ff, tx_active_in;
   logic             pop_rx_ff, pop_rx_in;

   logic tx_wr, rx_wr, tx_rd, rx_rd;
   logic tx_empty, tx_full, rx_empty, rx_full;

   logic       load_res;
   logic       line_load_in, write_acc_in, read_valid_in, rx_drop_in;
   logic [7:0] line_byte_in, read_byte_in;

   logic       line_load_ff, write_acc_ff, read_valid_ff, rx_drop_ff, busy_ff;
   logic [7:0] line_byte_ff, read_byte_ff;

   req_kind_type kind;

   assign kind = req_kind_type'(req_type);

   assign tx_head_nxt = (tx_head_ff == PTR_LAST) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_nxt = (tx_tail_ff == PTR_LAST) ? '0 : tx_tail_ff + 1'b1;
   assign rx_head_nxt = (rx_head_ff == PTR_LAST) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_nxt = (rx_tail_ff == PTR_LAST) ? '0 : rx_tail_ff + 1'b1;

   assign tx_empty = (tx_head_ff == tx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (tx_head_nxt == tx_tail_ff);
   assign rx_full  = (rx_head_nxt == rx_tail_ff);

   always_comb begin
      tx_wr = 1'b0;
      rx_wr = 1'b0;
      tx_rd = 1'b0;
      rx_rd = 1'b0;
      tx_active_in  = tx_active_ff;
      line_load_in  = 1'b0;
      line_byte_in  = '0;
      write_acc_in  = 1'b0;
      read_valid_in = 1'b0;
      read_byte_in  = '0;
      rx_drop_in    = 1'b0;
      stat.pop_needed = 1'b0;
      case (kind)
         REQ_WRITE: begin
            if (!tx_active_ff) begin
               tx_active_in = 1'b1;
               line_load_in = 1'b1;
               line_byte_in = data_byte;
               write_acc_in = 1'b1;
            end else if (!tx_full) begin
               tx_wr        = cmd.exec;
               write_acc_in = 1'b1;
            end
         end
         REQ_READ: begin
            if (!rx_empty) begin
               rx_rd           = cmd.exec;
               stat.pop_needed = 1'b1;
            end
         end
         REQ_RX: begin
            if (!rx_full) rx_wr = cmd.exec;
            else rx_drop_in = 1'b1;
         end
         REQ_TXDONE: begin
            if (!tx_empty) begin
               tx_rd           = cmd.exec;
               stat.pop_needed = 1'b1;
            end else begin
               tx_active_in = 1'b0;
            end
         end
         default: ;
      endcase

      // queue read has landed: result comes from the registered read data
      if (cmd.load_pop) begin
         line_load_in  = !pop_rx_ff;
         line_byte_in  = pop_rx_ff ? 8'd0 : tx_rd_ff;
         write_acc_in  = 1'b0;
         read_valid_in = pop_rx_ff;
         read_byte_in  = pop_rx_ff ? rx_rd_ff : 8'd0;
         rx_drop_in    = 1'b0;
      end
   end

   assign load_res   = (cmd.exec && !stat.pop_needed) || cmd.load_pop;
   assign tx_head_in = tx_wr ? tx_head_nxt : tx_head_ff;
   assign rx_head_in = rx_wr ? rx_head_nxt : rx_head_ff;
   assign tx_tail_in = tx_rd ? tx_tail_nxt : tx_tail_ff;
   assign rx_tail_in = rx_rd ? rx_tail_nxt : rx_tail_ff;
   assign pop_rx_in  = (cmd.exec && stat.pop_needed) ? rx_rd : pop_rx_ff;

   always_ff @(posedge clock) begin
      if (tx_wr) tx_mem[tx_head_ff] <= data_byte;
      if (tx_rd) tx_rd_ff <= tx_mem[tx_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (rx_wr) rx_mem[rx_head_ff] <= data_byte;
      if (rx_rd) rx_rd_ff <= rx_mem[rx_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_active_ff <= 1'b0;
      end else begin
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         if (cmd.exec) tx_active_ff <= tx_active_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_rx_ff <= pop_rx_in;
      if (load_res) begin
         line_load_ff  <= line_load_in;
         line_byte_ff  <= line_byte_in;
         write_acc_ff  <= write_acc_in;
         read_valid_ff <= read_valid_in;
         read_byte_ff  <= read_byte_in;
         rx_drop_ff    <= rx_drop_in;
         busy_ff       <= cmd.load_pop ? tx_active_ff : tx_active_in;
      end
   end

   assign line_load      = line_load_ff;
   assign line_byte      = line_byte_ff;
   assign write_accepted = write_acc_ff;
   assign read_valid     = read_valid_ff;
   assign read_byte      = read_byte_ff;
   assign rx_dropped     = rx_drop_ff;
   assign busy_flag      = busy_ff;

endmodule
